// File: design/array_linked_list_engine_defines.svh
// assertion macros shared by the array linked list engine modules
// no dependencies; clk and rst_n must exist in the including scope
`ifndef ARRAY_LINKED_LIST_ENGINE_DEFINES_SVH
`define ARRAY_LINKED_LIST_ENGINE_DEFINES_SVH

// same-cycle implication
`define ALLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ALLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/alle_pkg.sv
// shared types and constants for the array linked list engine
// no dependencies
package alle_pkg;

  localparam int LIST_SLOTS_DEF = 16;
  localparam int VALUE_W        = 32;
  localparam int FUNC_W         = 2;
  localparam int SLOT_W         = 4;

  localparam logic [FUNC_W-1:0] FUNC_PREPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;
  } alle_in_t;

  typedef struct packed {
    logic              success;
    logic [SLOT_W-1:0] slot;
  } alle_out_t;

  typedef enum logic [1:0] {
    SRC_FAIL,
    SRC_NEW,
    SRC_INS,
    SRC_CUR
  } alle_src_t;

  typedef struct packed {
    logic      latch_in;
    logic      ins_head;
    logic      ins_tail;
    logic      walk_begin;
    logic      walk_step;
    logic      link_patch;
    logic      res_load;
    alle_src_t res_src;
  } alle_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              head_empty;
    logic              link_end;
    logic              match;
  } alle_sts_t;

endpackage

// File: design/alle_datapath.sv
// slot stores, head and free pointers, walk cursor and result register
// depends on alle_pkg and array_linked_list_engine_defines.svh
`include "array_linked_list_engine_defines.svh"

module alle_datapath #(
  parameter int LIST_SLOTS = alle_pkg::LIST_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  alle_pkg::alle_in_t in_data,
  input  alle_pkg::alle_cmd_t cmd,
  output alle_pkg::alle_sts_t sts,
  output alle_pkg::alle_out_t res
);

  localparam int SW = $clog2(LIST_SLOTS);
  localparam int LW = $clog2(LIST_SLOTS + 1);
  localparam logic [LW-1:0] END_LINK = LW'(LIST_SLOTS);

  logic [alle_pkg::VALUE_W-1:0] vmem [LIST_SLOTS];
  logic [LW-1:0]                lmem [LIST_SLOTS];

  logic [alle_pkg::FUNC_W-1:0]  func_r;
  logic [alle_pkg::VALUE_W-1:0] val_r;
  logic [LW-1:0]                head_r;
  logic [LW-1:0]                free_r;
  logic [SW-1:0]                cur_r;
  logic [SW-1:0]                ins_r;
  logic [alle_pkg::VALUE_W-1:0] val_q;
  logic [LW-1:0]                link_q;
  alle_pkg::alle_out_t          res_r;

  logic [SW-1:0] free_idx;
  logic [SW-1:0] rd_addr;
  logic          rd_en;
  logic          do_ins;

  function automatic logic [alle_pkg::SLOT_W-1:0] to_slot(input logic [SW-1:0] s);
    logic [SW+alle_pkg::SLOT_W-1:0] e;
    e = (SW + alle_pkg::SLOT_W)'(s);
    return e[alle_pkg::SLOT_W-1:0];
  endfunction

  assign free_idx = free_r[SW-1:0];
  assign rd_addr  = cmd.walk_begin ? head_r[SW-1:0] : link_q[SW-1:0];
  assign rd_en    = cmd.walk_begin | cmd.walk_step;
  assign do_ins   = cmd.ins_head | cmd.ins_tail;

  // slot stores
  always_ff @(posedge clk) begin
    if (do_ins) begin
      vmem[free_idx] <= val_r;
    end
    if (cmd.ins_head) begin
      lmem[free_idx] <= head_r;
    end else if (cmd.ins_tail) begin
      lmem[free_idx] <= END_LINK;
    end else if (cmd.link_patch) begin
      lmem[cur_r] <= LW'(ins_r);
    end
    if (rd_en) begin
      val_q  <= vmem[rd_addr];
      link_q <= lmem[rd_addr];
      cur_r  <= rd_addr;
    end
  end

  // list pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= END_LINK;
      free_r <= '0;
    end else begin
      if (cmd.ins_head || (cmd.ins_tail && head_r == END_LINK)) begin
        head_r <= free_r;
      end
      if (do_ins) begin
        free_r <= free_r + LW'(1);
      end
    end
  end

  // beat latch, new slot and result
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      func_r <= in_data.func;
      val_r  <= in_data.value;
    end
    if (cmd.ins_tail) begin
      ins_r <= free_idx;
    end
    if (cmd.res_load) begin
      case (cmd.res_src)
        alle_pkg::SRC_NEW: res_r <= '{success: 1'b1, slot: to_slot(free_idx)};
        alle_pkg::SRC_INS: res_r <= '{success: 1'b1, slot: to_slot(ins_r)};
        alle_pkg::SRC_CUR: res_r <= '{success: 1'b1, slot: to_slot(cur_r)};
        default:           res_r <= '{success: 1'b0, slot: '0};
      endcase
    end
  end

  assign sts.func       = func_r;
  assign sts.full       = (free_r == END_LINK);
  assign sts.head_empty = (head_r == END_LINK);
  assign sts.link_end   = (link_q >= END_LINK);
  assign sts.match      = (val_q == val_r);
  assign res            = res_r;

  `ALLE_ASSERT_NOW(a_free_range, 1'b1, free_r <= END_LINK, "free pointer past store")
  `ALLE_ASSERT_NOW(a_head_free, 1'b1, (head_r == END_LINK) == (free_r == '0),
    "list emptiness disagrees with free pointer")

endmodule

// File: design/alle_ctrl.sv
// sequencer for insert, tail walk and search; owns the output valid
// depends on alle_pkg and array_linked_list_engine_defines.svh
`include "array_linked_list_engine_defines.svh"

module alle_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  alle_pkg::alle_sts_t sts,
  output alle_pkg::alle_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WALK
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   res_ok;

  assign res_ok = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '{res_src: alle_pkg::SRC_FAIL, default: 1'b0};
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_START;
        end
      end
      ST_START: begin
        case (sts.func)
          alle_pkg::FUNC_PREPEND: begin
            if (res_ok) begin
              cmd.res_load = 1'b1;
              state_nxt    = ST_IDLE;
              if (!sts.full) begin
                cmd.ins_head = 1'b1;
                cmd.res_src  = alle_pkg::SRC_NEW;
              end
            end
          end
          alle_pkg::FUNC_APPEND: begin
            if (sts.full || sts.head_empty) begin
              if (res_ok) begin
                cmd.res_load = 1'b1;
                state_nxt    = ST_IDLE;
                if (!sts.full) begin
                  cmd.ins_tail = 1'b1;
                  cmd.res_src  = alle_pkg::SRC_NEW;
                end
              end
            end else begin
              cmd.ins_tail   = 1'b1;
              cmd.walk_begin = 1'b1;
              state_nxt      = ST_WALK;
            end
          end
          alle_pkg::FUNC_SEARCH: begin
            if (sts.head_empty) begin
              if (res_ok) begin
                cmd.res_load = 1'b1;
                state_nxt    = ST_IDLE;
              end
            end else begin
              cmd.walk_begin = 1'b1;
              state_nxt      = ST_WALK;
            end
          end
          default: begin
            if (res_ok) begin
              cmd.res_load = 1'b1;
              state_nxt    = ST_IDLE;
            end
          end
        endcase
      end
      ST_WALK: begin
        if (sts.func == alle_pkg::FUNC_APPEND) begin
          if (!sts.link_end) begin
            cmd.walk_step = 1'b1;
          end else if (res_ok) begin
            cmd.link_patch = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_src    = alle_pkg::SRC_INS;
            state_nxt      = ST_IDLE;
          end
        end else begin
          if (sts.match || sts.link_end) begin
            if (res_ok) begin
              cmd.res_load = 1'b1;
              cmd.res_src  = sts.match ? alle_pkg::SRC_CUR : alle_pkg::SRC_FAIL;
              state_nxt    = ST_IDLE;
            end
          end else begin
            cmd.walk_step = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = cmd.res_load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  `ALLE_ASSERT_NOW(a_load_free, cmd.res_load, !out_valid_r || !out_stall,
    "result loaded over a waiting beat")
  `ALLE_ASSERT_NEXT(a_accept_start, in_valid && !in_stall, state_r == ST_START,
    "accepted beat did not start")
  `ALLE_ASSERT_NOW(a_walk_cmd, cmd.walk_step || cmd.link_patch, state_r == ST_WALK,
    "walk command outside walk")

endmodule

// File: design/array_linked_list_engine.sv
// top level of the array linked list engine: controller plus datapath
// depends on alle_pkg, alle_ctrl and alle_datapath
//
//   channel | direction | handshake          | beat
//   in      | input     | in_valid/in_stall   | alle_in_t  (func, value)
//   out     | output    | out_valid/out_stall | alle_out_t (success, slot)
//
// prepend and operations that fail at once: latched in ST_IDLE,
//   result loaded in ST_START; append and search read up to LIST_SLOTS
//   links in ST_WALK, one link read per cycle, walking from the head
// one operation in flight; a waiting result does not block the next accept
// synchronous active-low reset; the free list starts as all slots in order,
//   so no clearing pass runs and the block takes a beat right after reset
module array_linked_list_engine #(
  parameter int LIST_SLOTS = alle_pkg::LIST_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  alle_pkg::alle_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output alle_pkg::alle_out_t out_data
);

  alle_pkg::alle_cmd_t cmd;
  alle_pkg::alle_sts_t sts;

  alle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  alle_datapath #(
    .LIST_SLOTS (LIST_SLOTS)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .res     (out_data)
  );

endmodule
